@@ sv/mcdpa_pkg.sv @@
package mcdpa_pkg;

	localparam int MAX_ELEMENTS = 16;
	localparam int MAX_FACTOR   = 256;

	localparam int DATA_W   = 32;
	localparam int SUM_W    = 40;
	localparam int IDX_W    = 4;
	localparam int COUNT_W  = 5;
	localparam int FACTOR_W = 9;
	localparam int GP_W     = 8;
	localparam int REM_W    = FACTOR_W;
	localparam int STEP_W   = 6;

	localparam int FIFO_DEPTH = 2;
	localparam int PTR_W      = 1;
	localparam int FCNT_W     = 2;

	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_MODE          = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_FACTOR        = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_ELEMENT_COUNT = 2'd2;

	localparam logic MODE_PICK    = 1'b0;
	localparam logic MODE_AVERAGE = 1'b1;

	typedef struct packed {
		logic                mode;
		logic [FACTOR_W-1:0] factor;
		logic [COUNT_W-1:0]  count;
		logic                restart;
	} cfg_t;

	typedef struct packed {
		logic                    div;
		logic signed [SUM_W-1:0] value;
		logic [IDX_W-1:0]        index;
		logic [FACTOR_W-1:0]     factor;
	} job_t;

endpackage

@@ sv/multichannel_decimator_pick_average_core.sv @@
// A picked or passed element reaches the result ports through the job queue and the result register;
// an average passes through the job queue, the divider and then the result register.
// Throughput: one input beat per cycle while the 2-entry job queue has room; each average
// result holds the back end while the divider loads it and then works one quotient bit per cycle.
// Reset: arst_n clears framing counters, queue and result slot; running sums need no clearing.
module multichannel_decimator_pick_average_core (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [mcdpa_pkg::REG_IDX_W-1:0]         cfg_index,
	input  logic [mcdpa_pkg::FACTOR_W-1:0]          cfg_data,
	input  logic                                    push,
	output logic                                    full,
	input  logic signed [mcdpa_pkg::DATA_W-1:0]     sample_value,
	output logic                                    empty,
	input  logic                                    pop,
	output logic signed [mcdpa_pkg::DATA_W-1:0]     out_value,
	output logic [mcdpa_pkg::IDX_W-1:0]             element_index
);

	logic                              mode_q;
	logic [mcdpa_pkg::FACTOR_W-1:0]    factor_q;
	logic [mcdpa_pkg::COUNT_W-1:0]     count_q;
	mcdpa_pkg::cfg_t                   cfg;
	mcdpa_pkg::job_t                   wr_job;
	mcdpa_pkg::job_t                   rd_job;
	logic                              q_wr;
	logic                              q_rd;
	logic                              q_full;
	logic                              q_empty;
	logic [mcdpa_pkg::DATA_W-1:0]      back_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= mcdpa_pkg::MODE_PICK;
			factor_q <= mcdpa_pkg::FACTOR_W'(1);
			count_q  <= mcdpa_pkg::COUNT_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				mcdpa_pkg::REG_MODE:          mode_q   <= cfg_data[0];
				mcdpa_pkg::REG_FACTOR:        factor_q <= cfg_data;
				mcdpa_pkg::REG_ELEMENT_COUNT: count_q  <= cfg_data[mcdpa_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// zero means one, oversize saturates
	always_comb begin
		cfg.mode = mode_q;
		if (factor_q == '0) begin
			cfg.factor = mcdpa_pkg::FACTOR_W'(1);
		end else if (factor_q > mcdpa_pkg::FACTOR_W'(mcdpa_pkg::MAX_FACTOR)) begin
			cfg.factor = mcdpa_pkg::FACTOR_W'(mcdpa_pkg::MAX_FACTOR);
		end else begin
			cfg.factor = factor_q;
		end
		if (count_q == '0) begin
			cfg.count = mcdpa_pkg::COUNT_W'(1);
		end else if (count_q > mcdpa_pkg::COUNT_W'(mcdpa_pkg::MAX_ELEMENTS)) begin
			cfg.count = mcdpa_pkg::COUNT_W'(mcdpa_pkg::MAX_ELEMENTS);
		end else begin
			cfg.count = count_q;
		end
		cfg.restart = cfg_we && ((cfg_index == mcdpa_pkg::REG_MODE) ||
		              (cfg_index == mcdpa_pkg::REG_FACTOR) ||
		              (cfg_index == mcdpa_pkg::REG_ELEMENT_COUNT));
	end

	mcdpa_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.push         (push),
		.sample_value (sample_value),
		.q_full       (q_full),
		.full         (full),
		.q_wr         (q_wr),
		.q_job        (wr_job)
	);

	mcdpa_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_job  (wr_job),
		.rd      (q_rd),
		.rd_job  (rd_job),
		.q_full  (q_full),
		.q_empty (q_empty)
	);

	mcdpa_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job           (rd_job),
		.q_empty       (q_empty),
		.q_rd          (q_rd),
		.pop           (pop),
		.empty         (empty),
		.out_value     (back_value),
		.element_index (element_index)
	);

	assign out_value = back_value;

endmodule

@@ sv/mcdpa_front.sv @@
module mcdpa_front (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  mcdpa_pkg::cfg_t                         cfg,
	input  logic                                    push,
	input  logic signed [mcdpa_pkg::DATA_W-1:0]     sample_value,
	input  logic                                    q_full,
	output logic                                    full,
	output logic                                    q_wr,
	output mcdpa_pkg::job_t                         q_job
);

	logic [mcdpa_pkg::IDX_W-1:0]          elem_q;
	logic [mcdpa_pkg::GP_W-1:0]           group_q;
	logic signed [mcdpa_pkg::SUM_W-1:0]   sums_q [mcdpa_pkg::MAX_ELEMENTS];

	logic                                 accept;
	logic [mcdpa_pkg::IDX_W-1:0]          e;
	logic signed [mcdpa_pkg::SUM_W-1:0]   x_ext;
	logic signed [mcdpa_pkg::SUM_W-1:0]   sum_new;
	logic [mcdpa_pkg::COUNT_W-1:0]        e_next;
	logic [mcdpa_pkg::FACTOR_W-1:0]       g_next;
	logic                                 first;
	logic                                 last;
	logic                                 produce;

	assign full   = q_full;
	assign accept = push && !q_full;

	always_comb begin
		e = (mcdpa_pkg::COUNT_W'(elem_q) >= cfg.count) ? '0 : elem_q;
		x_ext   = mcdpa_pkg::SUM_W'(sample_value);
		first   = (group_q == '0);
		sum_new = first ? x_ext : sums_q[e] + x_ext;
		e_next  = mcdpa_pkg::COUNT_W'(e) + 1'b1;
		g_next  = mcdpa_pkg::FACTOR_W'(group_q) + 1'b1;
		last    = (g_next >= cfg.factor);
		produce = (cfg.mode == mcdpa_pkg::MODE_PICK) ? first : last;
	end

	assign q_wr = accept && produce;

	always_comb begin
		q_job.div    = (cfg.mode == mcdpa_pkg::MODE_AVERAGE) &&
		               (cfg.factor != mcdpa_pkg::FACTOR_W'(1));
		q_job.value  = q_job.div ? sum_new : x_ext;
		q_job.index  = e;
		q_job.factor = cfg.factor;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_q  <= '0;
			group_q <= '0;
		end else if (cfg.restart) begin
			elem_q  <= '0;
			group_q <= '0;
		end else if (accept) begin
			if (e_next >= cfg.count) begin
				elem_q  <= '0;
				group_q <= last ? '0 : g_next[mcdpa_pkg::GP_W-1:0];
			end else begin
				elem_q <= e_next[mcdpa_pkg::IDX_W-1:0];
			end
		end
	end

	// first beat of a group overwrites, so sums need no clearing
	always_ff @(posedge clk) begin
		if (accept) begin
			sums_q[e] <= sum_new;
		end
	end

endmodule

@@ sv/mcdpa_fifo.sv @@
module mcdpa_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  mcdpa_pkg::job_t wr_job,
	input  logic            rd,
	output mcdpa_pkg::job_t rd_job,
	output logic            q_full,
	output logic            q_empty
);

	mcdpa_pkg::job_t                 mem_q [mcdpa_pkg::FIFO_DEPTH];
	logic [mcdpa_pkg::PTR_W-1:0]     wptr_q;
	logic [mcdpa_pkg::PTR_W-1:0]     rptr_q;
	logic [mcdpa_pkg::FCNT_W-1:0]    cnt_q;
	logic                            do_wr;
	logic                            do_rd;

	assign q_full  = (cnt_q == mcdpa_pkg::FCNT_W'(mcdpa_pkg::FIFO_DEPTH));
	assign q_empty = (cnt_q == '0);
	assign do_wr   = wr && !q_full;
	assign do_rd   = rd && !q_empty;
	assign rd_job  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= mcdpa_pkg::FCNT_W'(mcdpa_pkg::FIFO_DEPTH))
		else $error("fifo count overflow");

	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		(do_wr && !do_rd) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("fifo count missed a write");

endmodule

@@ sv/mcdpa_back.sv @@
module mcdpa_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mcdpa_pkg::job_t                     job,
	input  logic                                q_empty,
	output logic                                q_rd,
	input  logic                                pop,
	output logic                                empty,
	output logic [mcdpa_pkg::DATA_W-1:0]        out_value,
	output logic [mcdpa_pkg::IDX_W-1:0]         element_index
);

	logic                              busy_q;
	logic [mcdpa_pkg::STEP_W-1:0]      step_q;
	logic [mcdpa_pkg::SUM_W-1:0]       quo_q;
	logic [mcdpa_pkg::REM_W-1:0]       rem_q;
	logic [mcdpa_pkg::FACTOR_W-1:0]    div_q;
	logic                              neg_q;
	logic [mcdpa_pkg::IDX_W-1:0]       idx_q;
	logic                              res_valid_q;
	logic [mcdpa_pkg::DATA_W-1:0]      res_value_q;
	logic [mcdpa_pkg::IDX_W-1:0]       res_idx_q;

	logic                              take;
	logic                              pop_ok;
	logic                              done;
	logic [mcdpa_pkg::REM_W+1:0]       shifted;
	logic [mcdpa_pkg::REM_W+1:0]       diff;
	logic                              qbit;
	logic [mcdpa_pkg::REM_W-1:0]       rem_next;
	logic [mcdpa_pkg::SUM_W-1:0]       quo_next;
	logic [mcdpa_pkg::SUM_W-1:0]       quo_signed;

	assign pop_ok = pop && res_valid_q;
	assign take   = !q_empty && !busy_q && (!res_valid_q || pop);
	assign q_rd   = take;
	assign done   = busy_q && (step_q == '0);

	assign empty         = !res_valid_q;
	assign out_value     = res_value_q;
	assign element_index = res_idx_q;

	// restoring divide of the magnitude, one quotient bit per cycle
	always_comb begin
		shifted    = {1'b0, rem_q, quo_q[mcdpa_pkg::SUM_W-1]};
		diff       = shifted - {2'b00, div_q};
		qbit       = !diff[mcdpa_pkg::REM_W+1];
		rem_next   = qbit ? diff[mcdpa_pkg::REM_W-1:0] : shifted[mcdpa_pkg::REM_W-1:0];
		quo_next   = {quo_q[mcdpa_pkg::SUM_W-2:0], qbit};
		quo_signed = neg_q ? (~quo_next + 1'b1) : quo_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			res_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			if (pop_ok) begin
				res_valid_q <= 1'b0;
			end
			if (take && job.div) begin
				busy_q <= 1'b1;
				step_q <= mcdpa_pkg::STEP_W'(mcdpa_pkg::SUM_W - 1);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (done) begin
					busy_q <= 1'b0;
				end
			end
			if ((take && !job.div) || done) begin
				res_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (job.div) begin
				neg_q <= job.value[mcdpa_pkg::SUM_W-1];
				quo_q <= job.value[mcdpa_pkg::SUM_W-1] ? (~job.value + 1'b1) : job.value;
				rem_q <= '0;
				div_q <= job.factor;
				idx_q <= job.index;
			end else begin
				res_value_q <= job.value[mcdpa_pkg::DATA_W-1:0];
				res_idx_q   <= job.index;
			end
		end else if (busy_q) begin
			quo_q <= quo_next;
			rem_q <= rem_next;
			if (done) begin
				res_value_q <= quo_signed[mcdpa_pkg::DATA_W-1:0];
				res_idx_q   <= idx_q;
			end
		end
	end

	a_busy_no_res: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !res_valid_q)
		else $error("divider running while result slot is occupied");

	a_done_res: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (res_valid_q && !busy_q))
		else $error("quotient not delivered");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import mcdpa_pkg::*;

	localparam logic [REG_IDX_W-1:0] REG_NONE = 2'd3;
	localparam int RANDOM_ITEMS  = 600;
	localparam int SETTLE_CYCLES = 60;
	localparam int HOLD_CYCLES   = 300;
	localparam int END_LIMIT     = 20000;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic [IDX_W-1:0]         index;
	} result_beat_t;

	// Tracks the framing and per-element sums, and holds the outputs still owed.
	class decimation_tracker;
		logic                mode;
		logic [FACTOR_W-1:0] factor_reg;
		logic [COUNT_W-1:0]  count_reg;
		int unsigned         elem_pos;
		int unsigned         group_pos;
		longint              sums [MAX_ELEMENTS];
		result_beat_t        awaited_outputs [$];
		int                  errors;
		int                  produced;

		function new();
			mode = MODE_PICK;
			factor_reg = FACTOR_W'(1);
			count_reg = COUNT_W'(1);
			errors = 0;
			produced = 0;
			restart();
		endfunction

		function void restart();
			elem_pos = 0;
			group_pos = 0;
			foreach (sums[i]) sums[i] = 0;
		endfunction

		function int unsigned eff_factor();
			if (factor_reg == 0) return 1;
			if (factor_reg > MAX_FACTOR) return MAX_FACTOR;
			return factor_reg;
		endfunction

		function int unsigned eff_count();
			if (count_reg == 0) return 1;
			if (count_reg > MAX_ELEMENTS) return MAX_ELEMENTS;
			return count_reg;
		endfunction

		function void apply_register(logic [REG_IDX_W-1:0] idx, logic [FACTOR_W-1:0] data);
			case (idx)
				REG_MODE: begin
					mode = data[0];
				end
				REG_FACTOR: begin
					factor_reg = data;
				end
				REG_ELEMENT_COUNT: begin
					count_reg = data[COUNT_W-1:0];
				end
				default: begin
					return;
				end
			endcase
			restart();
		endfunction

		function void take_sample(logic signed [DATA_W-1:0] v);
			int unsigned f;
			int unsigned n;
			int unsigned e;
			longint quotient;
			result_beat_t beat;
			f = eff_factor();
			n = eff_count();
			e = elem_pos;
			if (group_pos == 0) sums[e] = longint'(v);
			else sums[e] += longint'(v);
			beat.index = e[IDX_W-1:0];
			if (mode == MODE_PICK) begin
				if (group_pos == 0) begin
					beat.value = v;
					awaited_outputs.push_back(beat);
					produced++;
				end
			end else if (group_pos + 1 >= f) begin
				// integer division truncates toward zero, as the block must
				quotient = sums[e] / longint'(f);
				beat.value = quotient[DATA_W-1:0];
				awaited_outputs.push_back(beat);
				produced++;
			end
			e++;
			if (e >= n) begin
				e = 0;
				group_pos++;
				if (group_pos >= f) group_pos = 0;
			end
			elem_pos = e;
		endfunction

		function void match_output(logic signed [DATA_W-1:0] got_value,
				logic [IDX_W-1:0] got_index);
			result_beat_t want;
			if (awaited_outputs.size() == 0) begin
				$error("unexpected result beat: out_value %0d element_index %0d",
					got_value, got_index);
				errors++;
				return;
			end
			want = awaited_outputs.pop_front();
			if (got_value !== want.value) begin
				$error("out_value expected %0d, got %0d", want.value, got_value);
				errors++;
			end
			if (got_index !== want.index) begin
				$error("element_index expected %0d, got %0d", want.index, got_index);
				errors++;
			end
		endfunction
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_we;
	logic [REG_IDX_W-1:0]        cfg_index;
	logic [FACTOR_W-1:0]         cfg_data;
	logic                        push;
	logic                        full;
	logic signed [DATA_W-1:0]    sample_value;
	logic                        empty;
	logic                        pop;
	logic signed [DATA_W-1:0]    out_value;
	logic [IDX_W-1:0]            element_index;

	decimation_tracker book = new();
	bit calm;
	bit hold_request;
	int fed;

	multichannel_decimator_pick_average_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.push         (push),
		.full         (full),
		.sample_value (sample_value),
		.empty        (empty),
		.pop          (pop),
		.out_value    (out_value),
		.element_index(element_index)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 25);
	endfunction

	function automatic logic [DATA_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 32'h7FFF_FFFF;
		if (r == 1) return 32'h8000_0000;
		if (r == 2) return 32'($urandom_range(0, 8)) - 32'd4;
		return $urandom();
	endfunction

	// all tasks start and end on a falling edge
	task automatic send_sample(input logic [DATA_W-1:0] v);
		int gap;
		sample_value <= v;
		push <= 1'b1;
		@(posedge clk);
		while (full) @(posedge clk);
		book.take_sample(v);
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [FACTOR_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		book.apply_register(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// waits until no result is still awaited, then adds an extra settling wait
	task automatic settle();
		push <= 1'b0;
		while (book.awaited_outputs.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic random_phase(input bit big, input logic [FACTOR_W-1:0] big_factor);
		logic [FACTOR_W-1:0] data;
		logic [FACTOR_W-1:0] fac;
		logic [COUNT_W-1:0]  cnt;
		int r;
		int span;
		int items;
		calm = ($urandom_range(0, 4) == 0);
		if (big) begin
			fac = big_factor;
			cnt = COUNT_W'($urandom_range(0, 1));
		end else begin
			fac = ($urandom_range(0, 7) == 0) ? 9'd0 : 9'($urandom_range(1, 6));
			r = $urandom_range(0, 15);
			if (r < 2) cnt = COUNT_W'($urandom_range(17, 31));
			else if (r == 2) cnt = 0;
			else cnt = COUNT_W'($urandom_range(1, 16));
		end
		if (big || $urandom_range(0, 3) != 0) begin
			data = FACTOR_W'($urandom_range(0, 511));
			data[0] = 1'($urandom_range(0, 1));
			write_reg(REG_MODE, data);
		end
		if (big || $urandom_range(0, 3) != 0) write_reg(REG_FACTOR, fac);
		if (big || $urandom_range(0, 3) != 0) begin
			data = FACTOR_W'($urandom_range(0, 511));
			data[COUNT_W-1:0] = cnt;
			write_reg(REG_ELEMENT_COUNT, data);
		end
		if ($urandom_range(0, 5) == 0) write_reg(REG_NONE, 9'($urandom_range(0, 511)));
		span = book.eff_factor() * book.eff_count();
		items = big ? span : span * $urandom_range(1, 3);
		// now and then leave a partial group behind
		if ($urandom_range(0, 3) == 0) items += $urandom_range(0, span - 1);
		repeat (items) send_sample(pick_value());
		fed += items;
		settle();
	endtask

	always @(posedge clk) begin
		if (arst_n && pop && !empty) book.match_output(out_value, element_index);
	end

	initial begin : sink
		int stall;
		pop = 1'b0;
		stall = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				stall = HOLD_CYCLES;
			end
			if (stall > 0) begin
				pop <= 1'b0;
				stall--;
			end else begin
				pop <= 1'b1;
				stall = pick_gap();
			end
		end
	end

	initial begin
		#10_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin : stimulus
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		push = 1'b0;
		sample_value = '0;
		calm = 1'b0;
		hold_request = 1'b0;
		fed = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset setting: pick, factor one, single element
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h8000_0000);
		send_sample(32'h5555_5555);
		send_sample(32'hAAAA_AAAA);
		settle();

		// factor zero acts as one, element count above the maximum saturates
		write_reg(REG_MODE, {8'hFF, MODE_AVERAGE});
		write_reg(REG_FACTOR, 9'd0);
		write_reg(REG_ELEMENT_COUNT, 9'd20);
		for (int k = 0; k < MAX_ELEMENTS; k++)
			send_sample((k % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF);
		settle();

		// average extremes and truncation of a negative half
		write_reg(REG_FACTOR, 9'd2);
		write_reg(REG_ELEMENT_COUNT, 9'd3);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h8000_0000);
		send_sample(-32'sd3);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h8000_0000);
		send_sample(32'd0);
		settle();

		// a write past the register list must not restart the group
		write_reg(REG_ELEMENT_COUNT, 9'd0);
		send_sample(32'd5);
		settle();
		write_reg(REG_NONE, 9'h1FF);
		send_sample(32'd6);
		settle();

		// long receiver hold-off with the sender pushing back to back
		calm = 1'b1;
		write_reg(REG_MODE, {8'h00, MODE_PICK});
		write_reg(REG_FACTOR, 9'd1);
		write_reg(REG_ELEMENT_COUNT, 9'd3);
		hold_request = 1'b1;
		repeat (24) send_sample(pick_value());
		settle();

		random_phase(1'b1, 9'($urandom_range(257, 511)));
		while (fed < RANDOM_ITEMS)
			random_phase($urandom_range(0, 15) == 0,
				$urandom_range(0, 1) ? 9'd256 : 9'($urandom_range(200, 255)));

		push <= 1'b0;
		repeat (END_LIMIT) if (book.awaited_outputs.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (book.awaited_outputs.size() != 0) begin
			$error("%0d result beats never arrived", book.awaited_outputs.size());
			book.errors++;
		end
		if (book.errors == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

endmodule

@@ files.f @@
sv/mcdpa_pkg.sv
sv/mcdpa_front.sv
sv/mcdpa_fifo.sv
sv/mcdpa_back.sv
sv/multichannel_decimator_pick_average_core.sv
verif/tb.sv
